// ----- design/lz77tsd_pkg.sv -----
// lz77tsd_pkg: shared constants, state encoding and control structs for the
// lz77 token stream decoder. No dependencies; every other design file imports it.
`default_nettype none

package lz77tsd_pkg;

   // sizing of the history window and token fields
   localparam int WINDOW_DEPTH = 256;
   localparam int MIN_MATCH    = 4;
   localparam int LENGTH_BITS  = 4;

   localparam int BYTE_W  = 8;
   localparam int PTR_W   = $clog2(WINDOW_DEPTH);
   localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int BACK_W  = BYTE_W + 1;
   localparam int CMP_W   = (BACK_W > PTR_W + 1) ? BACK_W : PTR_W + 1;
   localparam int MAX_LEN = (1 << LENGTH_BITS) - 1 + MIN_MATCH;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);

   // fixed codes
   localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'h24;
   localparam logic [BYTE_W-1:0] ESCAPE_LIT_DIST = 8'h01;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_LIT  = 5'b00001,
      ST_HIGH = 5'b00010,
      ST_LOW  = 5'b00100,
      ST_READ = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_high;
      logic put_literal;
      logic put_escape;
      logic put_error;
      logic start_copy;
      logic read_hist;
      logic put_copy;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic match_escape;
      logic dist_one;
      logic too_far;
      logic out_free;
      logic copy_final;
   } sts_type;

endpackage

`default_nettype wire

// ----- design/lz77tsd_req_if.sv -----
// lz77tsd_req_if: valid/ready channel carrying compressed stream bytes.
// Depends on lz77tsd_pkg for the byte width.
`default_nettype none

interface lz77tsd_req_if;
   import lz77tsd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- design/lz77tsd_rsp_if.sv -----
// lz77tsd_rsp_if: valid/ready channel carrying decompressed bytes and flags.
// Depends on lz77tsd_pkg for the byte width.
`default_nettype none

interface lz77tsd_rsp_if;
   import lz77tsd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;
   logic              error;

   modport source (output valid, output out_byte, output last, output error, input ready);
   modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface

`default_nettype wire

// ----- design/lz77_token_stream_decoder.sv -----
// lz77_token_stream_decoder: top level joining controller and datapath.
// Depends on lz77tsd_pkg, lz77tsd_req_if, lz77tsd_rsp_if, lz77tsd_ctrl, lz77tsd_dpath.
//
// Decodes an LZ77 token stream one byte per request into decompressed bytes, keeping a
// 256-byte history ring. A literal byte gives one result; the first two bytes of a copy
// token give nothing; the third gives an escape literal or an error result, or starts a
// copy. A copy of length L (4 to 19) then holds off requests until its last byte is
// loaded: each byte takes a registered read of the history ram (ST_READ), then a write
// back and a load of the result register (ST_EMIT), which waits for a free output
// register. A result waits in the output register while the next literal is taken,
// provided the downstream takes it in the same cycle. The history ram needs no clearing
// after reset: the distance check against the fill count keeps reads inside the bytes
// written so far. The escape byte register resets to 0x24 and is written directly
// through csr_wr_en/csr_wr_data.
`default_nettype none

module lz77_token_stream_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [lz77tsd_pkg::BYTE_W-1:0] csr_wr_data,
   lz77tsd_req_if.sink                         req_ch,
   lz77tsd_rsp_if.source                       rsp_ch
);
   import lz77tsd_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   // control
   lz77tsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   lz77tsd_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_byte    (req_ch.in_byte),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_byte    (rsp_ch.out_byte),
      .rsp_last    (rsp_ch.last),
      .rsp_error   (rsp_ch.error)
   );

   assign req_ch.ready = req_ready;

   // no request taken while a history read is in flight
   a_no_req_during_read: assert property (@(posedge clock) disable iff (reset)
      cmd.read_hist |-> !(req_ch.valid && req_ready))
      else $error("request accepted during copy read");

   // history reads and copy writes alternate
   a_read_then_no_read: assert property (@(posedge clock) disable iff (reset)
      cmd.read_hist |=> !cmd.read_hist)
      else $error("back-to-back history reads");

   // at most one result source per cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.put_literal, cmd.put_escape, cmd.put_error, cmd.put_copy}))
      else $error("more than one result loaded");

   // a result is loaded only into a free output register
   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.put_literal || cmd.put_escape || cmd.put_error || cmd.put_copy)
         |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result overwrote a pending result");

endmodule

`default_nettype wire

// ----- design/lz77tsd_ctrl.sv -----
// lz77tsd_ctrl: token parsing and copy sequencing state machine.
// Depends on lz77tsd_pkg; drives commands into lz77tsd_dpath.
`default_nettype none

module lz77tsd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lz77tsd_pkg::sts_type sts,
   output lz77tsd_pkg::cmd_type   cmd
);
   import lz77tsd_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   // request side is open in the parsing states; result slot must be free in ST_LIT and ST_LOW
   always_comb begin
      case (state_ff)
         ST_LIT:  req_ready = sts.out_free;
         ST_HIGH: req_ready = 1'b1;
         ST_LOW:  req_ready = sts.out_free;
         default: req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid & req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LIT: begin
            if (accept) begin
               if (sts.match_escape) begin
                  state_in = ST_HIGH;
               end else begin
                  cmd.put_literal = 1'b1;
               end
            end
         end
         ST_HIGH: begin
            if (accept) begin
               cmd.load_high = 1'b1;
               state_in      = ST_LOW;
            end
         end
         ST_LOW: begin
            if (accept) begin
               if (sts.dist_one) begin
                  cmd.put_escape = 1'b1;
                  state_in       = ST_LIT;
               end else if (sts.too_far) begin
                  cmd.put_error = 1'b1;
                  state_in      = ST_LIT;
               end else begin
                  cmd.start_copy = 1'b1;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.read_hist = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.put_copy = 1'b1;
               state_in     = sts.copy_final ? ST_LIT : ST_READ;
            end
         end
         default: begin
            state_in = ST_LIT;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/lz77tsd_dpath.sv -----
// lz77tsd_dpath: history ram, pointers, escape register and result register.
// Depends on lz77tsd_pkg; commanded by lz77tsd_ctrl.
`default_nettype none

module lz77tsd_dpath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [lz77tsd_pkg::BYTE_W-1:0] csr_wr_data,
   input  wire logic [lz77tsd_pkg::BYTE_W-1:0] req_byte,
   input  wire lz77tsd_pkg::cmd_type           cmd,
   output lz77tsd_pkg::sts_type                sts,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output logic [lz77tsd_pkg::BYTE_W-1:0]      rsp_byte,
   output logic                                rsp_last,
   output logic                                rsp_error
);
   import lz77tsd_pkg::*;

   logic [BYTE_W-1:0] hist_mem [WINDOW_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [BYTE_W-1:0] esc_ff;
   logic [BYTE_W-1:0] high_ff;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  src_ff, src_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_error_ff, rsp_error_in;

   logic [BYTE_W-1:0] copy_dist;
   logic [BACK_W-1:0] back;
   logic [LEN_W-1:0]  len;
   logic [CMP_W-1:0]  wp_ext, back_ext, src_diff;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic              out_free;

   // token decode from the stored high byte and the current request byte
   assign copy_dist = high_ff | (req_byte >> LENGTH_BITS);
   assign back      = BACK_W'(copy_dist) + BACK_W'(1);
   assign len       = LEN_W'(req_byte[LENGTH_BITS-1:0]) + LEN_W'(MIN_MATCH);
   assign wp_ext    = CMP_W'(wp_ff);
   assign back_ext  = CMP_W'(back);

   // copy source position, wrapped into the window
   always_comb begin
      if (wp_ext >= back_ext) begin
         src_diff = wp_ext - back_ext;
      end else begin
         src_diff = wp_ext + CMP_W'(WINDOW_DEPTH) - back_ext;
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_ready;

   // status to the controller
   always_comb begin
      sts.match_escape = (req_byte == esc_ff);
      sts.dist_one     = (copy_dist == ESCAPE_LIT_DIST);
      sts.too_far      = (back_ext > CMP_W'(fill_ff));
      sts.out_free     = out_free;
      sts.copy_final   = (cnt_ff == LEN_W'(1));
   end

   // history write port
   assign wr_en = cmd.put_literal | cmd.put_escape | cmd.put_copy;
   always_comb begin
      if (cmd.put_copy) begin
         wr_data = rd_data_ff;
      end else if (cmd.put_escape) begin
         wr_data = esc_ff;
      end else begin
         wr_data = req_byte;
      end
   end

   // history ram, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wp_ff] <= wr_data;
      end
      if (cmd.read_hist) begin
         rd_data_ff <= hist_mem[src_ff];
      end
   end

   // pointer, fill and copy counter next values
   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      src_in  = src_ff;
      cnt_in  = cnt_ff;
      if (wr_en) begin
         wp_in = (wp_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
         if (fill_ff != FILL_W'(WINDOW_DEPTH)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      if (cmd.start_copy) begin
         src_in = src_diff[PTR_W-1:0];
         cnt_in = len;
      end else if (cmd.put_copy) begin
         src_in = (src_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : src_ff + PTR_W'(1);
         cnt_in = cnt_ff - LEN_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      if (cmd.put_literal | cmd.put_escape | cmd.put_copy | cmd.put_error) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cmd.put_error ? '0 : wr_data;
         rsp_last_in  = cmd.put_copy ? sts.copy_final : 1'b1;
         rsp_error_in = cmd.put_error;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff       <= ESCAPE_RESET;
         high_ff      <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            esc_ff <= csr_wr_data;
         end
         if (cmd.load_high) begin
            high_ff <= req_byte;
         end
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      cnt_ff       <= cnt_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_error = rsp_error_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for lz77_token_stream_decoder, random and directed byte streams
// decoded by a local window model and checked result by result under random stalls
// depends on lz77tsd_pkg, lz77tsd_req_if, lz77tsd_rsp_if and the decoder top level
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lz77tsd_pkg::*;

   localparam int LIMIT_CYCLES = 300000;
   localparam int IDLE_WAIT    = 8;
   localparam int TAIL_WAIT    = 60;

   typedef enum logic [1:0] {
      PH_OPEN,
      PH_DIST,
      PH_LEN
   } tok_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
      logic              error;
   } rsp_item_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;

   lz77tsd_req_if req_ch ();
   lz77tsd_rsp_if rsp_ch ();

   lz77_token_stream_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // local copy of the decoder state
   logic [BYTE_W-1:0] win_mem [0:WINDOW_DEPTH-1];
   logic [PTR_W-1:0]  win_wp;
   logic [FILL_W-1:0] win_fill;
   tok_phase_type     tok_phase;
   logic [BYTE_W-1:0] dist_hi;
   logic [BYTE_W-1:0] esc_cur;

   rsp_item_type pending_rsp [$];

   int  errors;
   int  items_sent;
   int  cycles;
   int  rsp_hold;
   bit  no_gaps;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout at %0t with %0d results outstanding", $time, pending_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   // window model helpers
   function automatic void window_put(input logic [BYTE_W-1:0] c);
      win_mem[win_wp] = c;
      win_wp = win_wp + 1'b1;
      if (win_fill < WINDOW_DEPTH)
         win_fill = win_fill + 1'b1;
   endfunction

   function automatic void expect_rsp(input logic [BYTE_W-1:0] c, input logic lst,
                                      input logic err);
      rsp_item_type it;
      it.out_byte = c;
      it.last     = lst;
      it.error    = err;
      pending_rsp.push_back(it);
   endfunction

   // decode one accepted request byte into the expected results
   function automatic void predict_decode(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] copy_dist;
      logic [BYTE_W-1:0] c;
      int unsigned len;
      int unsigned back;
      int unsigned pos;
      case (tok_phase)
         PH_DIST: begin
            dist_hi   = b;
            tok_phase = PH_LEN;
         end
         PH_LEN: begin
            tok_phase = PH_OPEN;
            copy_dist = dist_hi | (b >> LENGTH_BITS);
            len  = (b & ((1 << LENGTH_BITS) - 1)) + MIN_MATCH;
            back = int'(copy_dist) + 1;
            if (copy_dist == ESCAPE_LIT_DIST) begin
               window_put(esc_cur);
               expect_rsp(esc_cur, 1'b1, 1'b0);
            end else if (back > win_fill) begin
               expect_rsp('0, 1'b1, 1'b1);
            end else begin
               for (int k = 0; k < len; k++) begin
                  pos = (int'(win_wp) + WINDOW_DEPTH - back) % WINDOW_DEPTH;
                  c = win_mem[pos];
                  window_put(c);
                  expect_rsp(c, (k + 1 == len), 1'b0);
               end
            end
         end
         default: begin
            if (b == esc_cur) begin
               tok_phase = PH_DIST;
            end else begin
               window_put(b);
               expect_rsp(b, 1'b1, 1'b0);
            end
         end
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            errors = errors + 1;
            $display("%0t: expected no result, got byte=%02h last=%b error=%b", $time,
                     rsp_ch.out_byte, rsp_ch.last, rsp_ch.error);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_ch.out_byte !== want.out_byte || rsp_ch.last !== want.last ||
                rsp_ch.error !== want.error) begin
               errors = errors + 1;
               $display("%0t: expected byte=%02h last=%b error=%b, got %02h %b %b",
                        $time, want.out_byte, want.last, want.error,
                        rsp_ch.out_byte, rsp_ch.last, rsp_ch.error);
            end
         end
      end
   end

   // receiver with random stalls and an optional long hold-off
   initial begin : rsp_sink
      int gap;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end else begin
            gap = no_gaps ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // send one request byte, predict at acceptance
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_decode(b);
      items_sent++;
   endtask

   // copy token for distance d, length code len_code, high nibble a random subset
   task automatic send_copy_token(input logic [BYTE_W-1:0] d, input logic [3:0] len_code);
      logic [3:0] hi;
      hi = 4'($urandom_range(0, 15));
      send_byte(esc_cur);
      send_byte(d);
      send_byte({hi & d[3:0], len_code});
   endtask

   // stop sending until every expected result is in
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // write the escape register once the decoder is quiet
   task automatic set_escape(input logic [BYTE_W-1:0] v);
      drain_results();
      repeat (IDLE_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      esc_cur = v;
   endtask

   // literal extremes
   task automatic test_literals();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'hAA);
   endtask

   // distance one gives the escape byte itself
   task automatic test_escape_literal();
      send_copy_token(ESCAPE_LIT_DIST, 4'h0);
   endtask

   // overlapping copies: distance zero repeats the last byte, distance two at max length
   task automatic test_overlap_copy();
      send_copy_token(8'h00, 4'h0);
      send_copy_token(8'h02, 4'hF);
   endtask

   // distance past the stored bytes gives an error result
   task automatic test_far_distance();
      send_byte(esc_cur);
      send_byte(8'hFF);
      send_byte(8'hF0);
   endtask

   // token data bytes equal to the escape byte stay data
   task automatic test_token_bytes_equal_escape();
      send_byte(esc_cur);
      send_byte(esc_cur);
      send_byte(esc_cur);
   endtask

   // escape register rewritten between the second and third token byte
   task automatic test_escape_change_mid_token();
      send_byte(esc_cur);
      send_byte(8'h00);
      set_escape(8'hC3);
      send_byte(8'h1A);
   endtask

   // receiver holds off long enough to fill the decoder, then sender pauses
   task automatic test_output_backpressure();
      rsp_hold = 150;
      for (int i = 0; i < 12; i++)
         send_byte(8'($urandom_range(0, 254) + 1 + esc_cur));
      send_copy_token(8'h00, 4'h3);
      drain_results();
   endtask

   // random stream, mostly well-formed tokens and literals with some noise
   task automatic test_random_stream(input int n);
      int start;
      int r;
      int unsigned d;
      int unsigned fill;
      logic [BYTE_W-1:0] b;
      start = items_sent;
      while (items_sent - start < n) begin
         r = $urandom_range(0, 99);
         fill = 32'(win_fill);
         if (r < 50 || (r < 80 && fill == 0)) begin
            do b = 8'($urandom_range(0, 255)); while (b == esc_cur);
            send_byte(b);
         end else if (r < 80) begin
            if ($urandom_range(0, 7) == 0)
               d = fill - 1;
            else
               d = $urandom_range(0, fill - 1);
            if (d == ESCAPE_LIT_DIST)
               d = 0;
            send_copy_token(d[7:0], 4'($urandom_range(0, 15)));
         end else if (r < 87) begin
            if ($urandom_range(0, 1) == 0) begin
               send_copy_token(ESCAPE_LIT_DIST, 4'($urandom_range(0, 15)));
            end else begin
               send_byte(esc_cur);
               send_byte(8'h00);
               send_byte({4'h1, 4'($urandom_range(0, 15))});
            end
         end else if (r < 93 && fill < WINDOW_DEPTH) begin
            d = $urandom_range(fill, WINDOW_DEPTH - 1);
            if (d == ESCAPE_LIT_DIST)
               d = 2;
            send_copy_token(d[7:0], 4'($urandom_range(0, 15)));
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 49) == 0)
            drain_results();
      end
   endtask

   // main sequence
   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_ch.valid = 1'b0;
      req_ch.in_byte = '0;
      errors     = 0;
      items_sent = 0;
      rsp_hold   = 0;
      no_gaps    = 1'b0;
      win_wp     = '0;
      win_fill   = '0;
      tok_phase  = PH_OPEN;
      dist_hi    = '0;
      esc_cur    = ESCAPE_RESET;
      for (int i = 0; i < WINDOW_DEPTH; i++)
         win_mem[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_literals();
      test_escape_literal();
      test_overlap_copy();
      test_far_distance();
      test_token_bytes_equal_escape();
      test_escape_change_mid_token();
      test_output_backpressure();

      set_escape(8'h00);
      test_random_stream(55);
      set_escape(8'hFF);
      no_gaps = 1'b1;
      test_random_stream(25);
      no_gaps = 1'b0;
      test_random_stream(30);
      set_escape(8'($urandom_range(0, 255)));
      test_random_stream(55);
      set_escape(ESCAPE_RESET);
      test_random_stream(55);

      drain_results();
      repeat (TAIL_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
